[hdl/spq_pkg.sv]
// Shared operation codes, status codes and control types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_PORT_W = 32;
  localparam int unsigned PRIO_PORT_W = 16;
  localparam int unsigned COUNT_PORT_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

[hdl/sorted_priority_queue.sv]
// A result appears in the output register in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle without stalls; an insert or removal is one shift.
// A stalled result holds in the output register while the next transaction is still taken
// as long as the consumer frees the register in the same cycle.
// Reset empties the queue at once by clearing the cell valid bits and the entry count.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY       = 16,
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic [DATA_PORT_W-1:0]  item_data_i,
  input  logic [PRIO_PORT_W-1:0]  priority_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DATA_PORT_W-1:0]  result_data_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic                    is_empty_o,
  output logic [COUNT_PORT_W-1:0] entry_count_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // The queue is a row of cells kept in serving order, the head in cell 0.
  // An insert makes every cell compare its key with the new one in parallel;
  // cells behind the insertion point shift one place toward the tail and the
  // cell at the insertion point loads the new entry. A removal shifts every
  // cell one place toward the head.

  logic                      cell_valid [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_key   [CAPACITY];
  logic [DATA_WIDTH-1:0]     cell_data  [CAPACITY];
  logic                      cell_stay  [CAPACITY];
  logic [CAPACITY-1:0]       valid_vec;

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  cell_ctrl_t       ctrl;
  opcode_e          op;

  logic [DATA_WIDTH-1:0]     new_data;
  logic [PRIORITY_WIDTH-1:0] new_key;

  // Keep the low bits of the port fields, zero filling when the storage is wider.
  logic [DATA_WIDTH+DATA_PORT_W-1:0]     data_ext;
  logic [PRIORITY_WIDTH+PRIO_PORT_W-1:0] prio_ext;
  assign data_ext = {{DATA_WIDTH{1'b0}}, item_data_i};
  assign prio_ext = {{PRIORITY_WIDTH{1'b0}}, priority_req_i};
  assign new_data = data_ext[DATA_WIDTH-1:0];
  assign new_key  = prio_ext[PRIORITY_WIDTH-1:0];

  // The output register frees up when it is empty or drained this cycle.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = opcode_e'(opcode_i);

  logic                   is_full;
  logic                   is_empty_now;
  logic [STATUS_W-1:0]    status_d;
  logic [DATA_WIDTH-1:0]  head_data_d;

  assign is_full      = (count_q >= CNT_W'(CAPACITY));
  assign is_empty_now = (count_q == '0);

  // Decode the transaction into a cell command, the new count and the result.
  always_comb begin
    ctrl        = '0;
    count_d     = count_q;
    status_d    = ST_OK;
    head_data_d = '0;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_d     = count_q + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (is_empty_now) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.rem_en = 1'b1;
            head_data_d = cell_data[0];
            count_d     = count_q - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (is_empty_now) begin
            status_d = ST_EMPTY;
          end else begin
            head_data_d = cell_data[0];
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_stay, l_valid, r_valid;
    logic [PRIORITY_WIDTH-1:0] l_key, r_key;
    logic [DATA_WIDTH-1:0]     l_data, r_data;

    if (i == 0) begin : g_head
      // Nothing stands ahead of the head, so it loads the new entry directly.
      assign l_stay  = 1'b1;
      assign l_valid = 1'b0;
      assign l_key   = new_key;
      assign l_data  = new_data;
    end else begin : g_body
      assign l_stay  = cell_stay[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
      assign l_data  = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // The tail pulls in an empty slot on a removal.
      assign r_valid = 1'b0;
      assign r_key   = cell_key[i];
      assign r_data  = cell_data[i];
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_data  = cell_data[i+1];
    end

    spq_cell #(
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_key_i     (new_key),
      .new_data_i    (new_data),
      .left_stay_i   (l_stay),
      .left_valid_i  (l_valid),
      .left_key_i    (l_key),
      .left_data_i   (l_data),
      .right_valid_i (r_valid),
      .right_key_i   (r_key),
      .right_data_i  (r_data),
      .stay_o        (cell_stay[i]),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .data_o        (cell_data[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register. The payload carries no reset; only the valid flag does.
  logic                   out_valid_q, out_valid_d;
  logic [DATA_PORT_W-1:0] result_data_q, result_data_d;
  logic [STATUS_W-1:0]    status_q;
  logic                   is_empty_q;
  logic [COUNT_PORT_W-1:0] entry_count_q, entry_count_d;

  logic [DATA_WIDTH+DATA_PORT_W-1:0] res_ext;
  logic [CNT_W+COUNT_PORT_W-1:0]     cnt_ext;
  assign res_ext       = {{DATA_PORT_W{1'b0}}, head_data_d};
  assign cnt_ext       = {{COUNT_PORT_W{1'b0}}, count_d};
  assign result_data_d = res_ext[DATA_PORT_W-1:0];
  assign entry_count_d = cnt_ext[COUNT_PORT_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_data_q <= result_data_d;
      status_q      <= status_d;
      is_empty_q    <= (count_d == '0);
      entry_count_q <= entry_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_data_o = result_data_q;
  assign status_o      = status_q;
  assign is_empty_o    = is_empty_q;
  assign entry_count_o = entry_count_q;

  // The count register and the occupied cells must always agree.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("entry count disagrees with occupied cells");

  // The count never exceeds the number of cells.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Occupied cells form a prefix of the row, so the head is filled whenever any cell is.
  a_head_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> cell_valid[0])
    else $error("queue not empty but head cell is free");

  // A successful insert grows the queue by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // A transaction always leaves a result in the output register.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

endmodule

[hdl/spq_cell.sv]
// One slot of the sorted chain: holds a key and a data word and shifts toward either neighbor.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic [PRIORITY_WIDTH-1:0] new_key_i,
  input  logic [DATA_WIDTH-1:0]     new_data_i,
  input  logic                      left_stay_i,
  input  logic                      left_valid_i,
  input  logic [PRIORITY_WIDTH-1:0] left_key_i,
  input  logic [DATA_WIDTH-1:0]     left_data_i,
  input  logic                      right_valid_i,
  input  logic [PRIORITY_WIDTH-1:0] right_key_i,
  input  logic [DATA_WIDTH-1:0]     right_data_i,
  output logic                      stay_o,
  output logic                      valid_o,
  output logic [PRIORITY_WIDTH-1:0] key_o,
  output logic [DATA_WIDTH-1:0]     data_o
);

  logic                      valid_q, valid_d;
  logic [PRIORITY_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0]     data_q, data_d;

  // A held entry of equal or greater priority stays ahead of the new item.
  assign stay_o = valid_q && ($signed(key_q) >= $signed(new_key_i));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (ctrl_i.ins_en && !stay_o) begin
      if (left_stay_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        data_d  = new_data_i;
      end else begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        data_d  = left_data_i;
      end
    end else if (ctrl_i.rem_en) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      data_d  = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign data_o  = data_q;

endmodule

[bench/tb_sorted_priority_queue.sv]
// Self-checking testbench for the sorted priority queue: directed corner cases, then random traffic.
`timescale 1ns / 100ps

module tb_sorted_priority_queue
  import spq_pkg::*;
();

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_OPS  = 1026;
  localparam int unsigned QUIET_OPS   = 150;

  // Expected contents of one result transaction.
  typedef struct {
    logic [DATA_PORT_W-1:0]  data;
    status_e                 status;
    logic                    empty;
    logic [COUNT_PORT_W-1:0] count;
  } queue_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [OPCODE_W-1:0]     opcode_i       = OP_PEEK;
  logic [DATA_PORT_W-1:0]  item_data_i    = '0;
  logic [PRIO_PORT_W-1:0]  priority_req_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b1;
  logic [DATA_PORT_W-1:0]  result_data_o;
  logic [STATUS_W-1:0]     status_o;
  logic                    is_empty_o;
  logic [COUNT_PORT_W-1:0] entry_count_o;

  sorted_priority_queue #(
    .CAPACITY      (CAPACITY),
    .DATA_WIDTH    (DATA_PORT_W),
    .PRIORITY_WIDTH(PRIO_PORT_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .item_data_i   (item_data_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_data_o (result_data_o),
    .status_o      (status_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the queue, kept in serving order: index 0 is the head.
  logic signed [PRIO_PORT_W-1:0] shadow_prio [CAPACITY];
  logic        [DATA_PORT_W-1:0] shadow_data [CAPACITY];
  int unsigned                   shadow_count = 0;

  queue_result_t pending_results [$];

  // Idling switches for the sender and the receiver.
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left      = 0;

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned n_insert   = 0;
  int unsigned n_remove   = 0;
  int unsigned n_peek     = 0;
  int unsigned n_dropped  = 0;
  int unsigned n_on_empty = 0;
  int unsigned n_results  = 0;

  // Applies one operation to the shadow queue and returns the result it must produce.
  // A new entry goes behind every entry of equal or higher priority, which keeps
  // equal priorities first come, first served.
  function automatic queue_result_t queue_apply(opcode_e op, logic [DATA_PORT_W-1:0] data,
                                                logic signed [PRIO_PORT_W-1:0] prio);
    queue_result_t outcome;
    int unsigned   pos;
    outcome.data   = '0;
    outcome.status = ST_OK;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (shadow_count >= CAPACITY) begin
          outcome.status = ST_FULL;
          n_dropped++;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_data[i] = shadow_data[i-1];
          end
          shadow_prio[pos] = prio;
          shadow_data[pos] = data;
          shadow_count++;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (op == OP_REMOVE) n_remove++;
        else n_peek++;
        if (shadow_count == 0) begin
          outcome.status = ST_EMPTY;
          n_on_empty++;
        end else begin
          outcome.data = shadow_data[0];
          if (op == OP_REMOVE) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_prio[i-1] = shadow_prio[i];
              shadow_data[i-1] = shadow_data[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    outcome.empty = (shadow_count == 0);
    outcome.count = shadow_count[COUNT_PORT_W-1:0];
    return outcome;
  endfunction

  // Drives one transaction and holds it until the block takes it. An optional gap
  // with valid low comes first. The expected result is queued at acceptance.
  task automatic issue_op(opcode_e op, logic [DATA_PORT_W-1:0] data,
                          logic [PRIO_PORT_W-1:0] prio);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    item_data_i    <= data;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(queue_apply(op, data, prio));
  endtask

  // Stops sending and waits until every queued expectation has been met.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    queue_result_t want;
    n_results++;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result with none expected, expected nothing, actual data %0h status %0d",
               $time, result_data_o, status_o);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("result_data", want.data, result_data_o);
      compare_field("status", 32'(want.status), 32'(status_o));
      compare_field("is_empty", 32'(want.empty), 32'(is_empty_o));
      compare_field("entry_count", 32'(want.count), 32'(entry_count_o));
    end
  endtask

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
  end

  // Receiver back-pressure: ready drops at random and comes back when the stall counter runs out.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready_i <= 1'b1;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(1, 5);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Priorities lean toward ties and the signed extremes, which stress the ordering.
  function automatic logic [PRIO_PORT_W-1:0] pick_priority();
    logic [PRIO_PORT_W-1:0] prio;
    case ($urandom_range(0, 3))
      0: prio = PRIO_PORT_W'($signed($urandom_range(0, 6)) - 3);
      1: prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: prio = PRIO_PORT_W'($urandom);
    endcase
    return prio;
  endfunction

  // Draws an operation; insert_pct steers the queue toward full or empty.
  function automatic opcode_e pick_op(int unsigned insert_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return OP_INSERT;
    if (roll < insert_pct + (100 - insert_pct) / 4) return OP_PEEK;
    return OP_REMOVE;
  endfunction

  // Remove and peek on the empty queue straight after reset.
  task automatic test_empty_reads();
    issue_op(OP_REMOVE, 32'hFFFF_FFFF, 16'h7FFF);
    issue_op(OP_PEEK, 32'h0000_0000, 16'h8000);
  endtask

  // Fills the queue with extreme data and priorities, including ties at both
  // ends of the priority range, then pushes one insert past capacity.
  task automatic test_fill_to_capacity();
    logic [PRIO_PORT_W-1:0] prio_list [CAPACITY] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0005, 16'h0005, 16'h7FFF,
      16'h8000, 16'h0005, 16'hFFFE, 16'h7FFE, 16'h8001, 16'h0000, 16'h5555, 16'hAAAA};
    logic [DATA_PORT_W-1:0] data_list [4] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int i = 0; i < CAPACITY; i++) begin
      issue_op(OP_INSERT, (i < 4) ? data_list[i] : $urandom, prio_list[i]);
    end
    issue_op(OP_INSERT, 32'hDEAD_BEEF, 16'h7FFF);
    issue_op(OP_PEEK, $urandom, PRIO_PORT_W'($urandom));
  endtask

  // A few removes confirm the order at the head of a full queue.
  task automatic test_head_order();
    repeat (4) issue_op(OP_REMOVE, $urandom, PRIO_PORT_W'($urandom));
  endtask

  // Random traffic in phases of 64 transactions; each phase picks a bias toward
  // filling, balance or draining, and turns the idling on or off. Partway through
  // the sender holds off until the queue has answered everything.
  task automatic test_random_traffic(int unsigned count);
    int unsigned bias;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 85;
          1: bias = 50;
          default: bias = 15;
        endcase
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      if (n == count / 2) wait_drained();
      issue_op(pick_op(bias), $urandom, pick_priority());
    end
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_steady_stream(int unsigned count);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      issue_op(pick_op((n % 100 < 50) ? 70 : 30), $urandom, pick_priority());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_fill_to_capacity();
    test_head_order();
    test_random_traffic(RANDOM_OPS - QUIET_OPS);
    test_steady_stream(QUIET_OPS);

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d removes, %0d peeks.",
             n_results, n_insert, n_remove, n_peek);
    $display("Inserts dropped on a full queue: %0d; reads of an empty queue: %0d.",
             n_dropped, n_on_empty);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
